/* rtl/rsc_pkg.sv */
package rsc_pkg;

  localparam int STACK_DEPTH = 64;
  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);

  typedef enum logic [3:0] {
    ACT_PUSH  = 4'd0,
    ACT_POP   = 4'd1,
    ACT_PEEK  = 4'd2,
    ACT_CLEAR = 4'd3,
    ACT_DUMP  = 4'd4,
    ACT_SWAP  = 4'd5,
    ACT_DUP   = 4'd6,
    ACT_ADD   = 4'd7,
    ACT_SUB   = 4'd8,
    ACT_MUL   = 4'd9,
    ACT_DIV   = 4'd10
  } action_t;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_EMPTY = 3'd1,
    ST_FEW   = 3'd2,
    ST_DIV0  = 3'd3,
    ST_FULL  = 3'd4
  } status_t;

  typedef struct packed {
    logic        start;
    logic [31:0] b;
    logic [31:0] a;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] q;
  } div_rsp_t;

endpackage

/* rtl/rpn_stack_calculator.sv */
// Push, clear and commands refused at once answer directly; pop, peek and
// duplicate first read the top entry; swap, add, subtract, multiply and
// divide by zero read both top entries; divide then runs the divider.
// Dump sends one word at a time, reading the next after the last is taken.
// One command at a time; the next is taken the cycle after the last result
// word. Reset (rst, synchronous) empties the stack; memory kept.
module rpn_stack_calculator (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // action[3:0], operand[35:4], zero fill
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // value[31:0], status[34:32], zero fill
  output logic        m_tlast
);

  typedef enum logic [3:0] {
    S_IDLE, S_RD_A, S_RD_B, S_EXEC, S_DIV, S_DUMP_RD, S_DUMP_OUT, S_OUT
  } state_t;

  state_t                 state, state_next;
  logic [3:0]             act, act_next;
  logic [31:0]            opnd, opnd_next;
  logic [rsc_pkg::CW-1:0] count, count_next;
  logic [rsc_pkg::CW-1:0] walk, walk_next;
  logic [31:0]            a, a_next;
  logic [31:0]            mem [rsc_pkg::STACK_DEPTH];
  logic [31:0]            rdata;
  logic [rsc_pkg::AW-1:0] raddr;
  logic                   re;
  logic [rsc_pkg::AW-1:0] waddr;
  logic [31:0]            wdata;
  logic                   we;
  logic [31:0]            mul_r, mul_r_next;
  logic                   div_start, div_start_next;
  logic                   m_tvalid_next;
  logic [39:0]            m_tdata_next;
  logic                   m_tlast_next;
  rsc_pkg::div_req_t      dreq;
  rsc_pkg::div_rsp_t      drsp;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

  rsc_divider u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  assign s_tready = (state == S_IDLE) && !m_tvalid;

  always_comb begin
    state_next     = state;
    act_next       = act;
    opnd_next      = opnd;
    count_next     = count;
    walk_next      = walk;
    a_next         = a;
    mul_r_next     = mul_r;
    div_start_next = 1'b0;
    m_tvalid_next  = m_tvalid && !m_tready;
    m_tdata_next   = m_tdata;
    m_tlast_next   = m_tlast;
    re             = 1'b0;
    raddr          = '0;
    we             = 1'b0;
    waddr          = '0;
    wdata          = '0;
    case (state)
      S_IDLE: begin
        if (s_tvalid && s_tready) begin
          act_next     = s_tdata[3:0];
          opnd_next    = s_tdata[35:4];
          m_tdata_next = '0;
          m_tlast_next = 1'b1;
          state_next   = S_OUT;
          case (s_tdata[3:0])
            rsc_pkg::ACT_PUSH: begin
              if (count == rsc_pkg::CW'(rsc_pkg::STACK_DEPTH)) begin
                m_tdata_next[34:32] = rsc_pkg::ST_FULL;
              end else begin
                we         = 1'b1;
                waddr      = count[rsc_pkg::AW-1:0];
                wdata      = s_tdata[35:4];
                count_next = count + 1'b1;
              end
            end
            rsc_pkg::ACT_CLEAR: count_next = '0;
            rsc_pkg::ACT_POP, rsc_pkg::ACT_PEEK, rsc_pkg::ACT_DUMP: begin
              if (count == '0) begin
                m_tdata_next[34:32] = rsc_pkg::ST_EMPTY;
              end else begin
                re         = 1'b1;
                raddr      = rsc_pkg::AW'(count - 1'b1);
                walk_next  = count - 1'b1;
                state_next = (s_tdata[3:0] == rsc_pkg::ACT_DUMP) ? S_DUMP_RD : S_RD_A;
              end
            end
            rsc_pkg::ACT_DUP: begin
              if (count == '0) begin
                m_tdata_next[34:32] = rsc_pkg::ST_FEW;
              end else if (count == rsc_pkg::CW'(rsc_pkg::STACK_DEPTH)) begin
                m_tdata_next[34:32] = rsc_pkg::ST_FULL;
              end else begin
                re         = 1'b1;
                raddr      = rsc_pkg::AW'(count - 1'b1);
                state_next = S_RD_A;
              end
            end
            rsc_pkg::ACT_SWAP, rsc_pkg::ACT_ADD, rsc_pkg::ACT_SUB,
            rsc_pkg::ACT_MUL, rsc_pkg::ACT_DIV: begin
              if (count < rsc_pkg::CW'(2)) begin
                m_tdata_next[34:32] = rsc_pkg::ST_FEW;
              end else begin
                re         = 1'b1;
                raddr      = rsc_pkg::AW'(count - 1'b1);
                state_next = S_RD_A;
              end
            end
            default: ;
          endcase
        end
      end
      S_RD_A: begin
        // rdata holds top entry
        a_next     = rdata;
        state_next = S_OUT;
        case (act)
          rsc_pkg::ACT_POP: begin
            m_tdata_next[31:0] = rdata;
            count_next         = count - 1'b1;
          end
          rsc_pkg::ACT_PEEK: m_tdata_next[31:0] = rdata;
          rsc_pkg::ACT_DUP: begin
            we         = 1'b1;
            waddr      = count[rsc_pkg::AW-1:0];
            wdata      = rdata;
            count_next = count + 1'b1;
          end
          default: begin
            re         = 1'b1;
            raddr      = rsc_pkg::AW'(count - 2'd2);
            state_next = S_RD_B;
          end
        endcase
      end
      S_RD_B: begin
        mul_r_next = a * rdata;
        state_next = S_EXEC;
        if (act == rsc_pkg::ACT_SWAP) begin
          we    = 1'b1;
          waddr = rsc_pkg::AW'(count - 1'b1);
          wdata = rdata;
        end
        opnd_next = rdata; // b
      end
      S_EXEC: begin
        state_next = S_OUT;
        case (act)
          rsc_pkg::ACT_SWAP: begin
            we    = 1'b1;
            waddr = rsc_pkg::AW'(count - 2'd2);
            wdata = a;
          end
          rsc_pkg::ACT_DIV: begin
            if (a == '0) begin
              count_next          = count - 2'd2;
              m_tdata_next[34:32] = rsc_pkg::ST_DIV0;
            end else begin
              div_start_next = 1'b1;
              state_next     = S_DIV;
            end
          end
          default: begin
            we         = 1'b1;
            waddr      = rsc_pkg::AW'(count - 2'd2);
            wdata      = (act == rsc_pkg::ACT_ADD) ? a + opnd :
                         (act == rsc_pkg::ACT_SUB) ? opnd - a : mul_r;
            count_next = count - 1'b1;
          end
        endcase
      end
      S_DIV: begin
        if (drsp.done) begin
          we         = 1'b1;
          waddr      = rsc_pkg::AW'(count - 2'd2);
          wdata      = drsp.q;
          count_next = count - 1'b1;
          state_next = S_OUT;
        end
      end
      S_DUMP_RD: begin
        if (!m_tvalid) begin
          m_tdata_next[31:0] = rdata;
          m_tlast_next       = (walk == '0);
          m_tvalid_next      = 1'b1;
          state_next         = S_DUMP_OUT;
        end
      end
      S_DUMP_OUT: begin
        if (m_tready) begin
          if (walk == '0) begin
            state_next = S_IDLE;
          end else begin
            re         = 1'b1;
            raddr      = rsc_pkg::AW'(walk - 1'b1);
            walk_next  = walk - 1'b1;
            state_next = S_DUMP_RD;
          end
        end
      end
      S_OUT: begin
        m_tvalid_next = 1'b1;
        state_next    = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      m_tvalid  <= 1'b0;
      div_start <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      m_tvalid  <= m_tvalid_next;
      div_start <= div_start_next;
    end
    act     <= act_next;
    opnd    <= opnd_next;
    walk    <= walk_next;
    a       <= a_next;
    mul_r   <= mul_r_next;
    m_tdata <= m_tdata_next;
    m_tlast <= m_tlast_next;
  end

  assign dreq = '{start: div_start, b: opnd, a: a};

endmodule

/* rtl/rsc_divider.sv */
module rsc_divider (
  input  logic              clk,
  input  logic              rst,
  input  rsc_pkg::div_req_t req,
  output rsc_pkg::div_rsp_t rsp
);

  logic [31:0] rem;
  logic [31:0] quo;
  logic [31:0] dvs;
  logic [5:0]  cnt;
  logic        busy;
  logic        neg;
  logic        done;
  logic [32:0] trial;

  // one quotient bit a cycle, restoring, on magnitudes
  assign trial = {rem, quo[31]} - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= !req.start && busy && (cnt == 6'd31);
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= 6'd0;
        rem  <= 32'd0;
        quo  <= req.b[31] ? 32'd0 - req.b : req.b;
        dvs  <= req.a[31] ? 32'd0 - req.a : req.a;
        neg  <= req.a[31] ^ req.b[31];
      end else if (busy) begin
        if (!trial[32]) begin
          rem <= trial[31:0];
          quo <= {quo[30:0], 1'b1};
        end else begin
          rem <= {rem[30:0], quo[31]};
          quo <= {quo[30:0], 1'b0};
        end
        cnt <= cnt + 6'd1;
        if (cnt == 6'd31) begin
          busy <= 1'b0;
        end
      end
    end
  end

  assign rsp = '{done: done, q: (neg ? 32'd0 - quo : quo)};

endmodule

/* bench/rpn_stack_calculator_checker.sv */
`timescale 1ns / 100ps
module rpn_stack_calculator_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [39:0] s_tdata,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [39:0] m_tdata,
  input  logic        m_tlast,
  output int          errors,
  output int          pending
);

  typedef struct packed {
    logic             [31:0] value;
    rsc_pkg::status_t        status;
    logic                    last;
  } result_t;

  result_t     expected_q[$];
  logic [31:0] model_stack[rsc_pkg::STACK_DEPTH];
  int          model_count;

  function automatic logic [31:0] quotient(logic [31:0] b, logic [31:0] a);
    logic [31:0] mb, ma, q;
    mb = b[31] ? -b : b;
    ma = a[31] ? -a : a;
    q = mb / ma;
    return (b[31] != a[31]) ? -q : q;
  endfunction

  function automatic void queue_result(logic [31:0] v, rsc_pkg::status_t s, logic l);
    result_t r;
    r.value = v;
    r.status = s;
    r.last = l;
    expected_q.push_back(r);
  endfunction

  function automatic void apply_command(logic [3:0] act, logic [31:0] opnd);
    logic [31:0] a, b, r;
    int          n;
    n = model_count;
    case (act)
      rsc_pkg::ACT_PUSH: begin
        if (n >= rsc_pkg::STACK_DEPTH) queue_result(0, rsc_pkg::ST_FULL, 1);
        else begin
          model_stack[n] = opnd;
          model_count = n + 1;
          queue_result(0, rsc_pkg::ST_OK, 1);
        end
      end
      rsc_pkg::ACT_POP, rsc_pkg::ACT_PEEK: begin
        if (n == 0) queue_result(0, rsc_pkg::ST_EMPTY, 1);
        else begin
          queue_result(model_stack[n-1], rsc_pkg::ST_OK, 1);
          if (act == rsc_pkg::ACT_POP) model_count = n - 1;
        end
      end
      rsc_pkg::ACT_CLEAR: begin
        model_count = 0;
        queue_result(0, rsc_pkg::ST_OK, 1);
      end
      rsc_pkg::ACT_DUMP: begin
        if (n == 0) queue_result(0, rsc_pkg::ST_EMPTY, 1);
        else for (int k = 0; k < n; k++)
          queue_result(model_stack[n-1-k], rsc_pkg::ST_OK, k + 1 == n);
      end
      rsc_pkg::ACT_SWAP: begin
        if (n < 2) queue_result(0, rsc_pkg::ST_FEW, 1);
        else begin
          a = model_stack[n-1];
          model_stack[n-1] = model_stack[n-2];
          model_stack[n-2] = a;
          queue_result(0, rsc_pkg::ST_OK, 1);
        end
      end
      rsc_pkg::ACT_DUP: begin
        if (n == 0) queue_result(0, rsc_pkg::ST_FEW, 1);
        else if (n >= rsc_pkg::STACK_DEPTH) queue_result(0, rsc_pkg::ST_FULL, 1);
        else begin
          model_stack[n] = model_stack[n-1];
          model_count = n + 1;
          queue_result(0, rsc_pkg::ST_OK, 1);
        end
      end
      rsc_pkg::ACT_ADD, rsc_pkg::ACT_SUB, rsc_pkg::ACT_MUL, rsc_pkg::ACT_DIV: begin
        if (n < 2) queue_result(0, rsc_pkg::ST_FEW, 1);
        else begin
          a = model_stack[n-1];
          b = model_stack[n-2];
          if (act == rsc_pkg::ACT_DIV && a == 0) begin
            model_count = n - 2;
            queue_result(0, rsc_pkg::ST_DIV0, 1);
          end else begin
            case (act)
              rsc_pkg::ACT_ADD: r = a + b;
              rsc_pkg::ACT_SUB: r = b - a;
              rsc_pkg::ACT_MUL: r = a * b;
              default: r = quotient(b, a);
            endcase
            model_stack[n-2] = r;
            model_count = n - 1;
            queue_result(0, rsc_pkg::ST_OK, 1);
          end
        end
      end
      default: queue_result(0, rsc_pkg::ST_OK, 1);
    endcase
  endfunction

  always @(posedge clk) begin
    result_t e;
    if (rst) begin
      model_count = 0;
      errors = 0;
      expected_q.delete();
    end else begin
      if (s_tvalid && s_tready) apply_command(s_tdata[3:0], s_tdata[35:4]);
      if (m_tvalid && m_tready) begin
        if (expected_q.size() == 0) begin
          $error("unexpected result word %h", m_tdata);
          errors++;
        end else begin
          e = expected_q.pop_front();
          if (m_tdata[31:0] !== e.value) begin
            $error("value: expected %h, got %h", e.value, m_tdata[31:0]);
            errors++;
          end
          if (m_tdata[34:32] !== e.status) begin
            $error("status: expected %0d, got %0d", e.status, m_tdata[34:32]);
            errors++;
          end
          if (m_tlast !== e.last) begin
            $error("last: expected %b, got %b", e.last, m_tlast);
            errors++;
          end
        end
      end
    end
    pending = expected_q.size();
  end

endmodule

/* bench/rpn_stack_calculator_tb.sv */
`timescale 1ns / 100ps
module rpn_stack_calculator_tb;

  logic        clk = 0;
  logic        rst = 1;
  logic        s_tvalid = 0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 0;
  logic [39:0] m_tdata;
  logic        m_tlast;
  int          errors;
  int          pending;
  int          send_idle = 0;
  int          recv_idle = 0;
  bit          hold_off = 0;

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  rpn_stack_calculator u_top (.*);

  rpn_stack_calculator_checker u_chk (.*);

  always @(posedge clk)
    m_tready <= !rst && !hold_off && ($urandom_range(99) >= recv_idle);

  task automatic send_cmd(rsc_pkg::action_t act, logic [31:0] opnd);
    while (send_idle > 0 && $urandom_range(99) < send_idle) begin
      s_tvalid <= 0;
      @(posedge clk);
    end
    s_tvalid <= 1;
    s_tdata <= {4'd0, opnd, 4'(act)};
    do @(posedge clk); while (!s_tready);
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3: return 32'($urandom_range(9));
      4: return -32'($urandom_range(9));
      default: return $urandom;
    endcase
  endfunction

  // random content, weighted toward arithmetic on a shallow-to-mid stack
  task automatic random_cmds(int count);
    int pick;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      if (pick < 30) send_cmd(rsc_pkg::ACT_PUSH, rand_word());
      else if (pick < 34) send_cmd(rsc_pkg::ACT_POP, $urandom);
      else if (pick < 38) send_cmd(rsc_pkg::ACT_PEEK, $urandom);
      else if (pick < 40) send_cmd(rsc_pkg::ACT_CLEAR, $urandom);
      else if (pick < 45) send_cmd(rsc_pkg::ACT_DUMP, $urandom);
      else if (pick < 50) send_cmd(rsc_pkg::ACT_SWAP, $urandom);
      else if (pick < 55) send_cmd(rsc_pkg::ACT_DUP, $urandom);
      else if (pick < 97)
        send_cmd(rsc_pkg::action_t'($urandom_range(rsc_pkg::ACT_ADD, rsc_pkg::ACT_DIV)),
                 $urandom);
      else send_cmd(rsc_pkg::action_t'($urandom_range(11, 15)), $urandom);
    end
  endtask

  initial begin
    #400000000;
    $display("FAIL rpn_stack_calculator");
    $finish;
  end

  initial begin
    repeat (10) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // empty-stack cases, then division, arithmetic and unknown-action cases
    send_cmd(rsc_pkg::ACT_POP, 0);
    send_cmd(rsc_pkg::ACT_PEEK, 0);
    send_cmd(rsc_pkg::ACT_DUMP, 0);
    send_cmd(rsc_pkg::ACT_DUP, 0);
    send_cmd(rsc_pkg::ACT_SWAP, 0);
    send_cmd(rsc_pkg::ACT_ADD, 0);
    send_cmd(rsc_pkg::ACT_PUSH, 32'h8000_0000);
    send_cmd(rsc_pkg::ACT_DIV, 0);
    send_cmd(rsc_pkg::ACT_PUSH, 32'hffff_ffff);
    send_cmd(rsc_pkg::ACT_DIV, 0);               // most negative / -1
    send_cmd(rsc_pkg::ACT_PUSH, 32'h7fff_ffff);
    send_cmd(rsc_pkg::ACT_PUSH, 0);
    send_cmd(rsc_pkg::ACT_DIV, 0);               // divide by zero eats both
    send_cmd(rsc_pkg::ACT_PUSH, -32'sd7);
    send_cmd(rsc_pkg::ACT_PUSH, 2);
    send_cmd(rsc_pkg::ACT_SUB, 0);
    send_cmd(rsc_pkg::ACT_DUP, 0);
    send_cmd(rsc_pkg::ACT_MUL, 0);
    send_cmd(rsc_pkg::ACT_PUSH, 32'h7fff_ffff);
    send_cmd(rsc_pkg::ACT_ADD, 0);
    send_cmd(rsc_pkg::ACT_PEEK, 0);
    send_cmd(rsc_pkg::action_t'(4'd15), 32'hffff_ffff);
    send_cmd(rsc_pkg::ACT_CLEAR, 0);
    // fill to full, starting while the receiver holds off, then overflow and dump
    fork
      begin
        hold_off = 1;
        repeat (300) @(posedge clk);
        hold_off = 0;
      end
      begin
        for (int i = 0; i < rsc_pkg::STACK_DEPTH; i++)
          send_cmd(rsc_pkg::ACT_PUSH, $urandom);
      end
    join
    send_cmd(rsc_pkg::ACT_PUSH, 1);
    send_cmd(rsc_pkg::ACT_DUP, 0);
    send_cmd(rsc_pkg::ACT_DUMP, 0);
    send_cmd(rsc_pkg::ACT_CLEAR, 0);

    send_idle = 19; recv_idle = 45;
    random_cmds(110);
    send_idle = 45; recv_idle = 19;
    random_cmds(110);
    send_idle = 0; recv_idle = 0;
    random_cmds(110);
    s_tvalid <= 0;
    @(posedge clk);

    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0 && pending == 0)
      $display("PASS rpn_stack_calculator");
    else
      $display("FAIL rpn_stack_calculator");
    $finish;
  end

endmodule
